### src/crpf_pkg.sv
// Shared types, constants and helpers for the Catmull-Rom path follower.
// No dependencies; every other file refers to this package by scoped names.
package crpf_pkg;

  localparam int MAX_POINTS      = 64;
  localparam int PT_AW           = $clog2(MAX_POINTS);
  localparam int CNT_W           = $clog2(MAX_POINTS + 1);
  localparam int COORD_BITS      = 32;
  localparam int PHASE_FRAC_BITS = 16;
  localparam int PHASE_W         = PHASE_FRAC_BITS + 1;
  localparam int V_W             = COORD_BITS + 8;
  localparam int P_W             = V_W + PHASE_W + 1;
  localparam int PT_W            = 3 * COORD_BITS;

  localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << PHASE_FRAC_BITS;

  localparam int ACT_W = 2;
  localparam logic [ACT_W-1:0] ACT_LOAD    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_TICK    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RESTART = 2'd2;

  localparam int COUNT_W   = 7;
  localparam int STEP_W    = 17;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DW    = 17;
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP  = 1'b1;
  localparam logic [COUNT_W-1:0]   COUNT_RESET     = 7'd4;
  localparam logic [STEP_W-1:0]    STEP_RESET      = 17'd1092;

  typedef struct packed {
    logic [ACT_W-1:0]             action;
    logic [PT_AW-1:0]             point_slot;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;
  } crpf_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic [PT_AW-1:0]             segment;
    logic                         path_done;
  } crpf_out_t;

  typedef struct packed {
    logic       take;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       cap_en;
    logic [1:0] cap_sel;
    logic       coef_en;
    logic       mul_en;
    logic       add_en;
    logic [1:0] add_sel;
    logic       out_ld;
  } crpf_cmd_t;

  typedef struct packed {
    logic tick;
  } crpf_stat_t;

  function automatic logic signed [COORD_BITS-1:0] sat_coord(
    input logic signed [V_W-1:0] v
  );
    logic signed [COORD_BITS-1:0] r;
    if ((&v[V_W-1:COORD_BITS-1]) || !(|v[V_W-1:COORD_BITS-1])) begin
      r = v[COORD_BITS-1:0];
    end else if (v[V_W-1]) begin
      r = {1'b1, {(COORD_BITS-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_BITS-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] pt_axis(
    input logic [PT_W-1:0] pt,
    input int              k
  );
    return pt[(3-k)*COORD_BITS-1 -: COORD_BITS];
  endfunction

endpackage

### src/crpf_ctrl.sv
// Sequencer for the path follower: input handshake, point reads, Horner steps
// and the result register handshake. Uses crpf_pkg.
module crpf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  crpf_pkg::crpf_stat_t stat,
  output crpf_pkg::crpf_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_CAP  = 3'd2;
  localparam logic [2:0] ST_COEF = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_ADD  = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.take = in_valid;
        if (in_valid && stat.tick) begin
          state_nxt = ST_RD;
          cnt_nxt   = 2'd0;
        end
      end
      ST_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = cnt_r;
        cmd.cap_en  = (cnt_r != 2'd0);
        cmd.cap_sel = cnt_r - 2'd1;
        cnt_nxt     = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          state_nxt = ST_CAP;
        end
      end
      ST_CAP: begin
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = 2'd3;
        state_nxt   = ST_COEF;
      end
      ST_COEF: begin
        cmd.coef_en = 1'b1;
        cnt_nxt     = 2'd0;
        state_nxt   = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_ADD;
      end
      ST_ADD: begin
        cmd.add_en  = 1'b1;
        cmd.add_sel = cnt_r;
        cnt_nxt     = cnt_r + 2'd1;
        state_nxt   = (cnt_r == 2'd2) ? ST_OUT : ST_MUL;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### src/crpf_datapath.sv
// Datapath: point table memory, config registers, phase/segment state,
// coefficient and Horner evaluation for three axes, result register. Uses crpf_pkg.
module crpf_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [crpf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [crpf_pkg::CFG_DW-1:0]        cfg_wdata,
  input  crpf_pkg::crpf_in_t                 in_data,
  input  crpf_pkg::crpf_cmd_t                cmd,
  output crpf_pkg::crpf_stat_t               stat,
  output crpf_pkg::crpf_out_t                out_data
);

  localparam int CB  = crpf_pkg::COORD_BITS;
  localparam int VW  = crpf_pkg::V_W;
  localparam int PW  = crpf_pkg::P_W;
  localparam int PHW = crpf_pkg::PHASE_W;
  localparam int AW  = crpf_pkg::PT_AW;
  localparam int CW  = crpf_pkg::CNT_W;

  logic [crpf_pkg::COUNT_W-1:0] point_count_r;
  logic [crpf_pkg::STEP_W-1:0]  phase_step_r;
  logic [PHW-1:0]               phase_r, phase_nxt;
  logic [AW-1:0]                seg_r, seg_nxt;
  logic                         done_r, done_nxt;

  logic [crpf_pkg::PT_W-1:0] pt_mem [crpf_pkg::MAX_POINTS];
  logic [crpf_pkg::PT_W-1:0] rd_q;
  logic [crpf_pkg::PT_W-1:0] pt_r [4];

  logic [CW-1:0]   cnt_eff;
  logic            direct;
  logic [AW-1:0]   src;
  logic [AW-1:0]   rd_addr;
  logic [PHW-1:0]  step_sat;
  logic [PHW:0]    sum;
  logic signed [PHW:0] t_s;

  logic signed [VW-1:0] coef_a [3];
  logic signed [VW-1:0] coef_b [3];
  logic signed [VW-1:0] coef_c [3];
  logic signed [VW-1:0] a_r [3];
  logic signed [VW-1:0] b_r [3];
  logic signed [VW-1:0] p1x2_r [3];
  logic signed [VW-1:0] v_r [3];
  logic signed [PW-1:0] prod_r [3];
  logic signed [CB-1:0] pos [3];
  crpf_pkg::crpf_out_t  out_r;

  assign stat.tick = (in_data.action == crpf_pkg::ACT_TICK);
  assign out_data  = out_r;

  assign cnt_eff = (int'(point_count_r) > crpf_pkg::MAX_POINTS) ?
                   CW'(crpf_pkg::MAX_POINTS) : CW'(point_count_r);

  // source point for the clamped cases
  always_comb begin
    direct = 1'b1;
    src    = AW'(1);
    if (cnt_eff < CW'(4) || seg_r == '0) begin
      src = AW'(1);
    end else if (CW'(seg_r) > cnt_eff - CW'(3)) begin
      src = AW'(cnt_eff - CW'(2));
    end else begin
      direct = 1'b0;
    end
  end

  assign rd_addr = direct ? src : seg_r + AW'(cmd.rd_sel) - AW'(1);

  // phase and segment update
  always_comb begin
    step_sat  = (int'(phase_step_r) > int'(crpf_pkg::PHASE_ONE)) ?
                crpf_pkg::PHASE_ONE : PHW'(phase_step_r);
    sum       = {1'b0, phase_r} + {1'b0, step_sat};
    phase_nxt = phase_r;
    seg_nxt   = seg_r;
    done_nxt  = done_r;
    if (cmd.take && in_data.action == crpf_pkg::ACT_RESTART) begin
      phase_nxt = '0;
    end else if (cmd.take && in_data.action == crpf_pkg::ACT_TICK) begin
      done_nxt = 1'b0;
      if (sum >= {1'b0, crpf_pkg::PHASE_ONE}) begin
        if (cnt_eff >= CW'(4) &&
            (CW+1)'(seg_r) + (CW+1)'(3) < (CW+1)'(cnt_eff)) begin
          seg_nxt   = seg_r + AW'(1);
          phase_nxt = PHW'(sum - {1'b0, crpf_pkg::PHASE_ONE});
        end else begin
          phase_nxt = crpf_pkg::PHASE_ONE;
          done_nxt  = 1'b1;
        end
      end else begin
        phase_nxt = PHW'(sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= crpf_pkg::COUNT_RESET;
      phase_step_r  <= crpf_pkg::STEP_RESET;
      phase_r       <= '0;
      seg_r         <= AW'(1);
      done_r        <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == crpf_pkg::CFG_POINT_COUNT) begin
        point_count_r <= cfg_wdata[crpf_pkg::COUNT_W-1:0];
      end
      if (cfg_we && cfg_index == crpf_pkg::CFG_PHASE_STEP) begin
        phase_step_r <= cfg_wdata[crpf_pkg::STEP_W-1:0];
      end
      phase_r <= phase_nxt;
      seg_r   <= seg_nxt;
      done_r  <= done_nxt;
    end
  end

  // point table
  always_ff @(posedge clk) begin
    if (cmd.take && in_data.action == crpf_pkg::ACT_LOAD) begin
      pt_mem[in_data.point_slot] <= {in_data.coord_x, in_data.coord_y, in_data.coord_z};
    end
    if (cmd.rd_en) begin
      rd_q <= pt_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      pt_r[cmd.cap_sel] <= rd_q;
    end
  end

  // a = p2-p0, b = 2p0-5p1+4p2-p3, c = -p0+3p1-3p2+p3
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [VW-1:0] p0, p1, p2, p3;
      p0 = VW'(crpf_pkg::pt_axis(pt_r[0], k));
      p1 = VW'(crpf_pkg::pt_axis(pt_r[1], k));
      p2 = VW'(crpf_pkg::pt_axis(pt_r[2], k));
      p3 = VW'(crpf_pkg::pt_axis(pt_r[3], k));
      coef_a[k] = p2 - p0;
      coef_b[k] = (p0 <<< 1) - (p1 <<< 2) - p1 + (p2 <<< 2) - p3;
      coef_c[k] = (p1 <<< 1) + p1 - (p2 <<< 1) - p2 + p3 - p0;
    end
  end

  assign t_s = $signed({1'b0, phase_r});

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (cmd.coef_en) begin
        a_r[k]    <= coef_a[k];
        b_r[k]    <= coef_b[k];
        p1x2_r[k] <= VW'(crpf_pkg::pt_axis(pt_r[1], k)) <<< 1;
        v_r[k]    <= coef_c[k];
      end else if (cmd.add_en) begin
        case (cmd.add_sel)
          2'd0:    v_r[k] <= VW'(prod_r[k] >>> crpf_pkg::PHASE_FRAC_BITS) + b_r[k];
          2'd1:    v_r[k] <= VW'(prod_r[k] >>> crpf_pkg::PHASE_FRAC_BITS) + a_r[k];
          default: v_r[k] <= VW'(prod_r[k] >>> crpf_pkg::PHASE_FRAC_BITS) + p1x2_r[k];
        endcase
      end
      if (cmd.mul_en) begin
        prod_r[k] <= PW'(v_r[k]) * PW'(t_s);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pos[k] = direct ? crpf_pkg::pt_axis(pt_r[1], k) : crpf_pkg::sat_coord(v_r[k] >>> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_r.pos_x     <= pos[0];
      out_r.pos_y     <= pos[1];
      out_r.pos_z     <= pos[2];
      out_r.segment   <= seg_r;
      out_r.path_done <= done_r;
    end
  end

endmodule

### src/catmull_rom_path_follower.sv
// Catmull-Rom path follower, top level. Uses crpf_pkg, crpf_ctrl, crpf_datapath.
// A taken tick word reaches the result register through 4 point table reads,
// 1 capture, 1 coefficient, 3 multiply/add pairs and 1 load, in that order.
// A tick word holds in_stall until its result is loaded, set by the single table read
// port and the shared Horner multiply per axis; load and restart words leave it low.
// Reset (rst_n, synchronous): phase 0, segment 1, point_count 4, phase_step 1092.
module catmull_rom_path_follower (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [crpf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [crpf_pkg::CFG_DW-1:0]    cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  crpf_pkg::crpf_in_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output crpf_pkg::crpf_out_t            out_data
);

  crpf_pkg::crpf_cmd_t  cmd;
  crpf_pkg::crpf_stat_t stat;

  crpf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  crpf_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.action == crpf_pkg::ACT_TICK) |=> in_stall)
    else $error("tick word did not start the sequence");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |=> out_valid)
    else $error("result load not presented");

  a_seg_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.segment != '0))
    else $error("segment index reached zero");
`endif

endmodule
